/* design/mfdr_pkg.sv */
// shared types, constants and helpers for the mono feedback delay reverb
// no dependencies; used by mfdr_store and mono_feedback_delay_reverb
`timescale 1ns / 1ps

package mfdr_pkg;

  localparam int MAX_DELAY = 8192;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int LEN_W     = 14;
  localparam int SAMPLE_W  = 16;
  localparam int OUT_W     = 17;
  localparam int WET_W     = 8;
  localparam int ACC_W     = 10;
  localparam int PROD_W    = 19;
  localparam int WET_SHIFT = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WET_AMOUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_OFFSET   = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 14'd1584;
  localparam logic [LEN_W-1:0] TAP_RESET = 14'd226;

  localparam logic signed [OUT_W-1:0] CLAMP_HI = 17'sd127;
  localparam logic signed [OUT_W-1:0] CLAMP_LO = -17'sd128;

  typedef struct packed {
    logic signed [7:0] l;
    logic signed [7:0] r;
  } pair_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pair_t             wr_data;
  } store_req_t;

  function automatic logic signed [7:0] clamp8(input logic signed [OUT_W-1:0] v);
    logic signed [7:0] res;
    if (v > CLAMP_HI) begin
      res = 8'sd127;
    end else if (v < CLAMP_LO) begin
      res = -8'sd128;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

/* design/mono_feedback_delay_reverb.sv */
// top level of the mono feedback delay reverb: config registers, sequencer,
// shared tap adder and wet multiply; depends on mfdr_pkg and mfdr_store
//
//  channel | handshake              | word
//  --------+------------------------+---------------------------------
//  input   | in_valid / in_stall    | left_in, right_in (16b signed)
//  output  | out_valid / out_stall  | left_out, right_out (17b signed)
//  config  | cfg_valid / cfg_ready  | cfg_index (2b), cfg_data (14b)
//
// a wet item goes through two store reads, four passes through one shared
// tap adder, one multiply and one write-back before the next accept
// a bypass item (wet amount zero) skips the store reads, taps, multiply and write-back
// after reset the store is swept to zero; in_stall is high
// meanwhile, config writes are taken at any time
// a result waits in the output register; the next input word is accepted
// while it waits, and the write-back waits for the register to free up
`timescale 1ns / 1ps

module mono_feedback_delay_reverb (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [mfdr_pkg::SAMPLE_W-1:0]    left_in,
  input  logic signed [mfdr_pkg::SAMPLE_W-1:0]    right_in,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [mfdr_pkg::OUT_W-1:0]       left_out,
  output logic signed [mfdr_pkg::OUT_W-1:0]       right_out,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mfdr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mfdr_pkg::LEN_W-1:0]              cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RD_POS,
    ST_RD_OTH,
    ST_TAP,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t state;

  // config registers
  logic [mfdr_pkg::WET_W-1:0] wet_amount;
  logic [mfdr_pkg::LEN_W-1:0] delay_length;
  logic [mfdr_pkg::LEN_W-1:0] tap_offset;

  // item registers
  logic signed [mfdr_pkg::SAMPLE_W-1:0] left_r;
  logic signed [mfdr_pkg::SAMPLE_W-1:0] right_r;
  logic                                 bypass;
  logic [mfdr_pkg::LEN_W-1:0]           len_r;
  logic [mfdr_pkg::LEN_W-1:0]           tap_r;
  logic [mfdr_pkg::ADDR_W-1:0]          pos_r;
  logic [mfdr_pkg::ADDR_W-1:0]          other_r;
  logic [mfdr_pkg::ADDR_W-1:0]          write_position;
  mfdr_pkg::pair_t                      pos_pair;
  logic [1:0]                           tap_cnt;
  logic signed [mfdr_pkg::ACC_W-1:0]    acc;
  logic signed [mfdr_pkg::PROD_W-1:0]   prod;

  mfdr_pkg::store_req_t req;
  mfdr_pkg::pair_t      rd_data;
  logic                 clr_busy;

  logic [mfdr_pkg::LEN_W-1:0]         len_eff;
  logic [mfdr_pkg::LEN_W-1:0]         tap_eff;
  logic [mfdr_pkg::LEN_W:0]           other_sum;
  logic [mfdr_pkg::ADDR_W-1:0]        other_next;
  logic [mfdr_pkg::LEN_W-1:0]         pos_inc;
  logic signed [7:0]                  tap_sel;
  logic signed [mfdr_pkg::ACC_W-1:0]  acc_next;
  logic signed [mfdr_pkg::ACC_W-1:0]  wet_val;
  logic signed [mfdr_pkg::OUT_W-1:0]  left_sum;
  logic signed [mfdr_pkg::OUT_W-1:0]  right_sum;
  logic                               in_acc;
  logic                               fin_go;

  assign cfg_ready = 1'b1;
  assign in_stall  = clr_busy || (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign fin_go    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_amount   <= '0;
      delay_length <= mfdr_pkg::LEN_RESET;
      tap_offset   <= mfdr_pkg::TAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfdr_pkg::REG_WET_AMOUNT:   wet_amount   <= cfg_data[mfdr_pkg::WET_W-1:0];
        mfdr_pkg::REG_DELAY_LENGTH: delay_length <= cfg_data;
        mfdr_pkg::REG_TAP_OFFSET:   tap_offset   <= cfg_data;
        default: ;
      endcase
    end
  end

  // length held to 1..MAX_DELAY, tap held to the length
  always_comb begin
    len_eff = delay_length;
    if (delay_length == '0) begin
      len_eff = mfdr_pkg::LEN_W'(1);
    end else if (delay_length > mfdr_pkg::LEN_W'(mfdr_pkg::MAX_DELAY)) begin
      len_eff = mfdr_pkg::LEN_W'(mfdr_pkg::MAX_DELAY);
    end
    tap_eff = (tap_offset > len_eff) ? len_eff : tap_offset;
  end

  always_comb begin
    other_sum = {2'b00, pos_r} + {1'b0, tap_r};
    if (other_sum >= {1'b0, len_r}) begin
      other_next = mfdr_pkg::ADDR_W'(other_sum - {1'b0, len_r});
    end else begin
      other_next = other_sum[mfdr_pkg::ADDR_W-1:0];
    end
    pos_inc = {1'b0, pos_r} + 1'b1;
  end

  // shared tap adder: one tap per cycle
  always_comb begin
    case (tap_cnt)
      2'd0:    tap_sel = pos_pair.l;
      2'd1:    tap_sel = pos_pair.r;
      2'd2:    tap_sel = rd_data.l;
      default: tap_sel = rd_data.r;
    endcase
    acc_next = acc + {{(mfdr_pkg::ACC_W-8){tap_sel[7]}}, tap_sel};
  end

  // arithmetic shift floors
  assign wet_val   = prod[mfdr_pkg::PROD_W-1:mfdr_pkg::WET_SHIFT];
  assign left_sum  = {left_r[mfdr_pkg::SAMPLE_W-1], left_r}
                   + {{(mfdr_pkg::OUT_W-mfdr_pkg::ACC_W){wet_val[mfdr_pkg::ACC_W-1]}}, wet_val};
  assign right_sum = {right_r[mfdr_pkg::SAMPLE_W-1], right_r}
                   + {{(mfdr_pkg::OUT_W-mfdr_pkg::ACC_W){wet_val[mfdr_pkg::ACC_W-1]}}, wet_val};

  always_comb begin
    req.rd_en     = (state == ST_RD_POS) || (state == ST_RD_OTH);
    req.rd_addr   = (state == ST_RD_POS) ? pos_r : other_r;
    req.wr_en     = (state == ST_FIN) && fin_go && !bypass;
    req.wr_addr   = pos_r;
    req.wr_data.l = mfdr_pkg::clamp8(left_sum);
    req.wr_data.r = mfdr_pkg::clamp8(right_sum);
  end

  mfdr_store u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      write_position <= '0;
      tap_cnt        <= '0;
    end else begin
      // a finishing item reloads the register instead
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            left_r  <= left_in;
            right_r <= right_in;
            bypass  <= (wet_amount == '0);
            len_r   <= len_eff;
            tap_r   <= tap_eff;
            prod    <= '0;
            state   <= (wet_amount == '0) ? ST_FIN : ST_PREP;
          end
        end
        ST_PREP: begin
          // a shrunk length can leave the position past the end
          pos_r <= ({1'b0, write_position} >= len_r) ? '0 : write_position;
          state <= ST_RD_POS;
        end
        ST_RD_POS: begin
          other_r <= other_next;
          acc     <= '0;
          tap_cnt <= '0;
          state   <= ST_RD_OTH;
        end
        ST_RD_OTH: begin
          pos_pair <= rd_data;
          state    <= ST_TAP;
        end
        ST_TAP: begin
          acc     <= acc_next;
          tap_cnt <= tap_cnt + 1'b1;
          if (tap_cnt == 2'd3) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= acc * $signed({1'b0, wet_amount});
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            out_valid <= 1'b1;
            left_out  <= left_sum;
            right_out <= right_sum;
            if (!bypass) begin
              write_position <= (pos_inc >= len_r) ? '0 : pos_inc[mfdr_pkg::ADDR_W-1:0];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // four 8-bit taps cannot sum above 508
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (acc <= 10'sd508))
    else $error("tap sum out of range");

  a_pos_in_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && fin_go && !bypass) |=> ({1'b0, write_position} < len_r))
    else $error("write position past delay length");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result word without a finished item");

  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (state == ST_IDLE))
    else $error("item in flight during store clear");

endmodule

/* design/mfdr_store.sv */
// delay store: 8-bit stereo pair memory with registered read and a
// clearing sweep after reset; depends on mfdr_pkg
`timescale 1ns / 1ps

module mfdr_store (
  input  logic                clk,
  input  logic                rst,
  input  mfdr_pkg::store_req_t req,
  output mfdr_pkg::pair_t     rd_data,
  output logic                clr_busy
);

  mfdr_pkg::pair_t mem [mfdr_pkg::MAX_DELAY];

  logic [mfdr_pkg::ADDR_W-1:0] clr_idx;

  // one entry a cycle from zero to the top after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      clr_busy <= 1'b1;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == mfdr_pkg::ADDR_W'(mfdr_pkg::MAX_DELAY - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_idx] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
